/* hw/rtl/diamond_difference_sweep_cell_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros for the diamond difference sweep cell
// ---------------------------------------------------------------------------
`ifndef DIAMOND_DIFFERENCE_SWEEP_CELL_MACROS_SVH
`define DIAMOND_DIFFERENCE_SWEEP_CELL_MACROS_SVH

// implication checked on every clock edge outside reset
`define DDS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define DDS_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* hw/rtl/dds_pkg.sv */
// ---------------------------------------------------------------------------
// dds_pkg
// shared types, constants and helpers of the sweep cell
// ---------------------------------------------------------------------------
package dds_pkg;

  localparam int unsigned MaxXDef     = 16;
  localparam int unsigned MaxYDef     = 16;
  localparam int unsigned MaxZDef     = 16;
  localparam int unsigned StoreDepth  = 256;
  localparam int unsigned IdxW        = 8;
  localparam int unsigned CosW        = 18;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned InDataW     = 176;
  localparam int unsigned OutDataW    = 32;

  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActSweep = 2'd1,
    ActRead  = 2'd2,
    ActNop   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CfgCosX = 2'd0,
    CfgCosY = 2'd1,
    CfgCosZ = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdWait,
    StTermX,
    StTermY,
    StTermZ,
    StProd,
    StDen,
    StFlux,
    StFace,
    StWrite,
    StOut
  } state_e;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return SatMax;
    end else if (v < -66'sd2147483648) begin
      return SatMin;
    end
    return v[31:0];
  endfunction

endpackage

/* hw/rtl/dds_divider.sv */
// ---------------------------------------------------------------------------
// dds_divider
// signed 64-bit restoring divider, one quotient bit per cycle, truncating
// ---------------------------------------------------------------------------
module dds_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dds_pkg::div_req_t req_i,
  output dds_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [63:0] num_abs;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    num_abs = req_i.num[63] ? 64'(-req_i.num) : req_i.num;
    trial   = {rem_q, quo_q[63]} - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      rem_d  = '0;
      quo_d  = num_abs;
      dvs_d  = req_i.den[63] ? 64'(-req_i.den) : req_i.den;
      neg_d  = req_i.num[63] ^ req_i.den[63];
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? 64'(-quo_q) : quo_q;

endmodule

/* hw/rtl/dds_face_mem.sv */
// ---------------------------------------------------------------------------
// dds_face_mem
// one face flux store, single write port, registered read
// ---------------------------------------------------------------------------
module dds_face_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [dds_pkg::IdxW-1:0]   waddr_i,
  input  logic [31:0]                wdata_i,
  input  logic [dds_pkg::IdxW-1:0]   raddr_i,
  output logic [31:0]                rdata_o
);

  logic [31:0] mem [dds_pkg::StoreDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/diamond_difference_sweep_cell.sv */
// ---------------------------------------------------------------------------
// diamond_difference_sweep_cell
// a sweep runs the divider for the three terms and, unless the denominator is zero, for the flux
// one item at a time; s_axis_tready is low while an item is in work or a result waits
// reset clears control and the direction cosines; face stores are not cleared
// ---------------------------------------------------------------------------
module diamond_difference_sweep_cell #(
  parameter int unsigned MAX_X = dds_pkg::MaxXDef,
  parameter int unsigned MAX_Y = dds_pkg::MaxYDef,
  parameter int unsigned MAX_Z = dds_pkg::MaxZDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dds_pkg::CosW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // face, x_pos, y_pos, z_pos, source_value, total_xs, delta_x, delta_y, delta_z
  input  logic [dds_pkg::InDataW-1:0]   s_axis_tdata,
  // action
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // flux_value
  output logic [dds_pkg::OutDataW-1:0]  m_axis_tdata,
  // from_face, div_fault
  output logic [1:0]                    m_axis_tuser
);

  dds_pkg::state_e state_q, state_d;

  logic signed [dds_pkg::CosW-1:0] cos_q [3];

  logic [1:0]        face_q;
  logic [3:0]        xp_q, yp_q, zp_q;
  logic signed [31:0] src_q, sigt_q;
  logic [30:0]       dx_q, dy_q, dz_q;
  logic [1:0]        act_q;
  logic signed [31:0] term_q [3];
  logic signed [31:0] fv_q [3];
  logic signed [65:0] num_q, den_q;
  logic signed [31:0] flux_q;
  logic              fault_q, from_q;
  logic              ovalid_q;
  logic [dds_pkg::IdxW-1:0] idx [3];
  logic [31:0]       rdata [3];
  logic              we [3];
  logic [31:0]       wdata [3];
  logic              started_q, started_d;
  dds_pkg::div_req_t dreq;
  dds_pkg::div_rsp_t drsp;
  logic signed [31:0] num32, den32;
  logic signed [63:0] prod [3];

  logic [1:0]  in_face;
  logic [3:0]  in_x, in_y, in_z;

  assign in_face = s_axis_tdata[1:0];
  assign in_x    = s_axis_tdata[5:2];
  assign in_y    = s_axis_tdata[9:6];
  assign in_z    = s_axis_tdata[13:10];

  function automatic logic [dds_pkg::IdxW-1:0] fidx(input logic [1:0] f,
      input logic [3:0] x, input logic [3:0] y, input logic [3:0] z);
    int unsigned xi, yi, zi, r;
    xi = int'(x) % MAX_X;
    yi = int'(y) % MAX_Y;
    zi = int'(z) % MAX_Z;
    if (f == 2'd0) r = yi * MAX_Z + zi;
    else if (f == 2'd1) r = xi * MAX_Z + zi;
    else r = xi * MAX_Y + yi;
    return r[dds_pkg::IdxW-1:0];
  endfunction

  assign idx[0] = fidx(2'd0, xp_q, yp_q, zp_q);
  assign idx[1] = fidx(2'd1, xp_q, yp_q, zp_q);
  assign idx[2] = fidx(2'd2, xp_q, yp_q, zp_q);

  for (genvar a = 0; a < 3; a++) begin : g_mem
    dds_face_mem u_mem (
      .clk_i  (clk_i),
      .we_i   (we[a]),
      .waddr_i(idx[a]),
      .wdata_i(wdata[a]),
      .raddr_i(idx[a]),
      .rdata_o(rdata[a])
    );
    assign prod[a] = 64'(fv_q[a]) * 64'(term_q[a]);
  end

  dds_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  assign num32 = dds_pkg::sat32(num_q);
  assign den32 = dds_pkg::sat32(den_q);
  assign s_axis_tready = (state_q == dds_pkg::StIdle) && !ovalid_q;
  assign cfg_ready_o   = 1'b1;

  function automatic logic [63:0] term_num(input logic signed [dds_pkg::CosW-1:0] c);
    return 64'(signed'(c)) <<< 17;
  endfunction

  function automatic logic [63:0] dpos(input logic [30:0] d);
    return (d == 31'd0) ? 64'd1 : {33'd0, d};
  endfunction

  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    for (int a = 0; a < 3; a++) begin
      we[a]    = 1'b0;
      wdata[a] = dds_pkg::sat32((66'(flux_q) <<< 1) - 66'(fv_q[a]));
    end
    unique case (state_q)
      dds_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (dds_pkg::action_e'(s_axis_tuser))
            dds_pkg::ActLoad:  state_d = dds_pkg::StWrite;
            dds_pkg::ActSweep,
            dds_pkg::ActRead:  state_d = dds_pkg::StRdWait;
            default:           state_d = dds_pkg::StIdle;
          endcase
        end
      end
      dds_pkg::StWrite: begin
        for (int a = 0; a < 3; a++) begin
          we[a]    = (face_q == 2'(a));
          wdata[a] = src_q;
        end
        state_d = dds_pkg::StIdle;
      end
      dds_pkg::StRdWait: begin
        state_d = (act_q == dds_pkg::ActRead) ? dds_pkg::StOut : dds_pkg::StTermX;
        started_d = 1'b0;
      end
      dds_pkg::StTermX, dds_pkg::StTermY, dds_pkg::StTermZ: begin
        dreq.start = !started_q;
        started_d  = 1'b1;
        unique case (state_q)
          dds_pkg::StTermX: begin
            dreq.num = term_num(cos_q[0]);
            dreq.den = dpos(dx_q);
          end
          dds_pkg::StTermY: begin
            dreq.num = term_num(cos_q[1]);
            dreq.den = dpos(dy_q);
          end
          default: begin
            dreq.num = term_num(cos_q[2]);
            dreq.den = dpos(dz_q);
          end
        endcase
        if (drsp.done) begin
          started_d = 1'b0;
          unique case (state_q)
            dds_pkg::StTermX: state_d = dds_pkg::StTermY;
            dds_pkg::StTermY: state_d = dds_pkg::StTermZ;
            default:          state_d = dds_pkg::StProd;
          endcase
        end
      end
      dds_pkg::StProd: state_d = dds_pkg::StDen;
      dds_pkg::StDen: begin
        started_d = 1'b0;
        state_d = (den32 == 32'sd0) ? dds_pkg::StFace : dds_pkg::StFlux;
      end
      dds_pkg::StFlux: begin
        dreq.start = !started_q;
        started_d  = 1'b1;
        dreq.num   = 64'(num32) <<< 16;
        dreq.den   = 64'(den32);
        if (drsp.done) begin
          started_d = 1'b0;
          state_d   = dds_pkg::StFace;
        end
      end
      dds_pkg::StFace: begin
        for (int a = 0; a < 3; a++) begin
          we[a] = 1'b1;
        end
        state_d = dds_pkg::StOut;
      end
      dds_pkg::StOut: state_d = dds_pkg::StIdle;
      default: state_d = dds_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dds_pkg::StIdle;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cos_q[a] <= '0;
      end
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      if (state_q == dds_pkg::StOut) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          dds_pkg::CfgCosX: cos_q[0] <= cfg_data_i;
          dds_pkg::CfgCosY: cos_q[1] <= cfg_data_i;
          dds_pkg::CfgCosZ: cos_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q  <= s_axis_tuser;
      face_q <= in_face;
      xp_q   <= in_x;
      yp_q   <= in_y;
      zp_q   <= in_z;
      src_q  <= s_axis_tdata[45:14];
      sigt_q <= s_axis_tdata[77:46];
      dx_q   <= s_axis_tdata[108:78];
      dy_q   <= s_axis_tdata[139:109];
      dz_q   <= s_axis_tdata[170:140];
    end
    if (state_q == dds_pkg::StRdWait) begin
      num_q <= 66'(src_q);
      den_q <= 66'(sigt_q);
    end
    // store read data is valid from the cycle after StRdWait on
    if (state_q == dds_pkg::StTermX) begin
      for (int a = 0; a < 3; a++) begin
        fv_q[a] <= rdata[a];
      end
    end
    if (drsp.done) begin
      unique case (state_q)
        dds_pkg::StTermX: term_q[0] <= dds_pkg::sat32(66'(drsp.quo));
        dds_pkg::StTermY: term_q[1] <= dds_pkg::sat32(66'(drsp.quo));
        dds_pkg::StTermZ: term_q[2] <= dds_pkg::sat32(66'(drsp.quo));
        default:          flux_q    <= dds_pkg::sat32(66'(drsp.quo));
      endcase
    end
    if (state_q == dds_pkg::StProd) begin
      num_q <= num_q + 66'(prod[0] >>> 16) + 66'(prod[1] >>> 16) + 66'(prod[2] >>> 16);
      den_q <= den_q + 66'(term_q[0]) + 66'(term_q[1]) + 66'(term_q[2]);
    end
    if (state_q == dds_pkg::StDen) begin
      fault_q <= (den32 == 32'sd0);
      if (den32 == 32'sd0) begin
        flux_q <= (num32 > 0) ? dds_pkg::SatMax :
                  ((num32 < 0) ? dds_pkg::SatMin : 32'sd0);
      end
    end
    if (state_q == dds_pkg::StOut) begin
      from_q <= (act_q == dds_pkg::ActRead);
      if (act_q == dds_pkg::ActRead) begin
        fault_q <= 1'b0;
        unique case (face_q)
          2'd0:    flux_q <= rdata[0];
          2'd1:    flux_q <= rdata[1];
          2'd2:    flux_q <= rdata[2];
          default: flux_q <= 32'sd0;
        endcase
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = flux_q;
  assign m_axis_tuser  = {fault_q, from_q};

endmodule

/* hw/rtl/dds_checker.sv */
// ---------------------------------------------------------------------------
// dds_checker
// port-level checks of the sweep cell
// ---------------------------------------------------------------------------
`include "diamond_difference_sweep_cell_macros.svh"

module dds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [1:0] m_axis_tuser
);

  `DDS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `DDS_ASSERT_IMP(a_read_no_fault, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1])
  `DDS_ASSERT_IMP(a_no_take_pending, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `DDS_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser != dds_pkg::ActNop), !s_axis_tready)

endmodule

bind diamond_difference_sweep_cell dds_checker u_dds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tuser (m_axis_tuser)
);
